FILE: rtl/core/lrt_pkg.sv
// ----------------------------------------------------------------------------
// LRU tracker package
// Shared sizes, operation and status codes, and the update word that the
// request decoder hands to the slot store.
// ----------------------------------------------------------------------------
package lrt_pkg;

	// Number of tracked keys and key width used for matching.
	localparam int CAPACITY      = 16;
	localparam int KEY_BITS      = 16;

	// Fixed widths of the request and result fields.
	localparam int OPCODE_BITS   = 2;
	localparam int KEY_PORT_BITS = 16;
	localparam int STATUS_BITS   = 2;
	localparam int COUNT_PORT_BITS = 5;

	// Derived storage widths.
	localparam int STORE_BITS = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
	localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int COUNT_BITS = $clog2(CAPACITY + 1);

	// Operation codes.
	localparam logic [OPCODE_BITS-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_BITS-1:0] OP_VICTIM = 2'd1;
	localparam logic [OPCODE_BITS-1:0] OP_ERASE  = 2'd2;

	// Status codes.
	localparam logic [STATUS_BITS-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

	typedef logic [STORE_BITS-1:0] key_t;
	typedef logic [CAPACITY-1:0]   slot_vec_t;

	// Update word from the decoder to the slot store.
	typedef struct packed {
		logic                  remove;
		slot_vec_t             remove_mask;
		logic                  append;
		logic [IDX_BITS-1:0]   append_idx;
		key_t                  append_key;
		logic [COUNT_BITS-1:0] count_next;
	} upd_t;

endpackage

FILE: rtl/core/lrt_match.sv
// ----------------------------------------------------------------------------
// LRU tracker key match
// Compares the request key against every valid slot in parallel and forms
// the mask of slots at and above the matching one.
// ----------------------------------------------------------------------------
module lrt_match import lrt_pkg::*; (
	input  key_t      [CAPACITY-1:0] slot_keys,
	input  slot_vec_t                slot_valid,
	input  key_t                     key,
	output logic                     hit,
	output slot_vec_t                tail_mask
);

	slot_vec_t match;

	// One comparator per slot.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = slot_valid[i] && (slot_keys[i] == key);
		end
	end

	assign hit = |match;

	// A slot is part of the tail when the match lies at or below it.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			tail_mask[i] = |(match & ((slot_vec_t'(1) << i) | ((slot_vec_t'(1) << i) - 1'b1)));
		end
	end

endmodule

FILE: rtl/core/lrt_store.sv
// ----------------------------------------------------------------------------
// LRU tracker slot store
// Holds the keys in recency order, the valid marks and the key count, and
// applies one removal with shift-down and one append per cycle with upd_en high.
// ----------------------------------------------------------------------------
module lrt_store import lrt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd_en,
	input  upd_t                       upd,
	output key_t      [CAPACITY-1:0]   slot_keys,
	output slot_vec_t                  slot_valid,
	output logic      [COUNT_BITS-1:0] count
);

	key_t      [CAPACITY-1:0]   keys_q;
	key_t      [CAPACITY-1:0]   keys_next;
	slot_vec_t                  valid_q;
	slot_vec_t                  valid_next;
	logic      [COUNT_BITS-1:0] count_q;

	// Shift the more recent keys down over the removed slot, then append.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			keys_next[i] = keys_q[i];
			if (upd.remove && upd.remove_mask[i] && (i < CAPACITY - 1)) begin
				keys_next[i] = keys_q[(i < CAPACITY - 1) ? i + 1 : i];
			end
			if (upd.append && (upd.append_idx == IDX_BITS'(i))) begin
				keys_next[i] = upd.append_key;
			end
		end
	end

	// Valid marks follow the count as a thermometer code.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			valid_next[i] = (COUNT_BITS'(i) < upd.count_next);
		end
	end

	// Key slots carry no reset; only valid slots are ever read.
	always_ff @(posedge clk) begin
		if (upd_en) begin
			keys_q <= keys_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (upd_en) begin
			valid_q <= valid_next;
			count_q <= upd.count_next;
		end
	end

	assign slot_keys  = keys_q;
	assign slot_valid = valid_q;
	assign count      = count_q;

endmodule

FILE: rtl/core/lru_replacement_tracker_core.sv
// ----------------------------------------------------------------------------
// LRU replacement tracker
// Keeps up to CAPACITY keys in recency order and serves insert, victim and
// erase requests with one result word per request word.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (opcode, key) is taken at a rising edge with start high
//   and busy low. busy is always low, so a word can be taken every cycle.
//   Each request gives exactly one result word (status, victim_key,
//   entry_count), shown for one cycle with done high.
// Pipeline and throughput:
//   The request is registered, decoded against the slot store in one pass
//   of compare-and-shift logic, and the result is registered: done comes
//   from the result register, behind the request register. One request per
//   cycle is sustained, set by the combinational associative compare and
//   one-slot shift of the store; back-to-back requests see each other's
//   updates in order.
// Reset:
//   arst_n clears the count and all valid marks; the tracker starts empty.
//   No clearing pass is needed.
// Stalls:
//   The receiver cannot hold results off; every result is shown once.
// ----------------------------------------------------------------------------
module lru_replacement_tracker_core import lrt_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [OPCODE_BITS-1:0]     opcode,
	input  logic [KEY_PORT_BITS-1:0]   key,
	output logic                       done,
	output logic [STATUS_BITS-1:0]     status,
	output logic [KEY_PORT_BITS-1:0]   victim_key,
	output logic [COUNT_PORT_BITS-1:0] entry_count
);

	logic                       valid_s1;
	logic [OPCODE_BITS-1:0]     opcode_s1;
	key_t                       key_s1;

	key_t      [CAPACITY-1:0]   slot_keys;
	slot_vec_t                  slot_valid;
	logic      [COUNT_BITS-1:0] count;
	logic                       hit;
	slot_vec_t                  tail_mask;

	upd_t                       upd;
	logic [STATUS_BITS-1:0]     status_next;
	logic [KEY_PORT_BITS-1:0]   victim_next;

	logic                       done_q;
	logic [STATUS_BITS-1:0]     status_q;
	logic [KEY_PORT_BITS-1:0]   victim_q;
	logic [COUNT_PORT_BITS-1:0] count_q;

	assign busy = 1'b0;

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			opcode_s1 <= opcode;
			key_s1    <= key[STORE_BITS-1:0];
		end
	end

	// Associative compare over all slots.
	lrt_match u_match (
		.slot_keys (slot_keys),
		.slot_valid(slot_valid),
		.key       (key_s1),
		.hit       (hit),
		.tail_mask (tail_mask)
	);

	// Decode the request into a store update and a result word.
	always_comb begin
		upd             = '0;
		upd.append_key  = key_s1;
		upd.count_next  = count;
		status_next     = ST_DONE;
		victim_next     = '0;
		case (opcode_s1)
			OP_INSERT: begin
				if (hit) begin
					upd.remove      = 1'b1;
					upd.remove_mask = tail_mask;
					upd.append      = 1'b1;
					upd.append_idx  = IDX_BITS'(count - 1'b1);
				end else if (count == COUNT_BITS'(CAPACITY)) begin
					status_next = ST_FULL;
				end else begin
					upd.append     = 1'b1;
					upd.append_idx = count[IDX_BITS-1:0];
					upd.count_next = count + 1'b1;
				end
			end
			OP_VICTIM: begin
				if (count == '0) begin
					status_next = ST_MISS;
				end else begin
					upd.remove      = 1'b1;
					upd.remove_mask = '1;
					upd.count_next  = count - 1'b1;
					victim_next[STORE_BITS-1:0] = slot_keys[0];
				end
			end
			OP_ERASE: begin
				if (hit) begin
					upd.remove      = 1'b1;
					upd.remove_mask = tail_mask;
					upd.count_next  = count - 1'b1;
				end else begin
					status_next = ST_MISS;
				end
			end
			default: begin
				status_next = ST_DONE;
			end
		endcase
	end

	// Recency-ordered slot storage.
	lrt_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (valid_s1),
		.upd       (upd),
		.slot_keys (slot_keys),
		.slot_valid(slot_valid),
		.count     (count)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q <= status_next;
			victim_q <= victim_next;
			count_q  <= COUNT_PORT_BITS'(upd.count_next);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign victim_key  = victim_q;
	assign entry_count = count_q;

endmodule
